FILE: hdl/tftpwr_pkg.sv
// Shared types and constants for the TFTP write receiver.
// No dependencies; imported by tftp_write_receiver_top.
package tftpwr_pkg;

    localparam int unsigned MaxBlock = 4096;

    localparam int unsigned LenW   = 13;
    localparam int unsigned BlockW = 16;
    localparam int unsigned SecW   = 11;
    localparam int unsigned OpW    = 16;
    localparam int unsigned AddrW  = 3;
    localparam int unsigned DataW  = 32;

    // Longest packet the receive buffer holds, header included
    localparam logic [LenW-1:0] LenCap    = LenW'(MaxBlock + 4);
    localparam logic [LenW-1:0] HdrLen    = LenW'(4);
    localparam logic [BlockW-1:0] BlockTop = '1;
    localparam logic [SecW-1:0] SecTop     = '1;

    localparam logic [OpW-1:0] OpData  = OpW'(3);
    localparam logic [OpW-1:0] OpError = OpW'(5);

    localparam logic [LenW-1:0] BlockSizeRst   = LenW'(512);
    localparam logic [SecW-1:0] SessionSecsRst = SecW'(20);

    typedef enum logic [1:0] {
        ACT_PACKET = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_EXPIRE = 2'd2,
        ACT_START  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_DONE = 2'd2,
        ST_FAIL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SEND_NONE  = 2'd0,
        SEND_ACK   = 2'd1,
        SEND_ERROR = 2'd2
    } t_send;

    typedef enum logic [2:0] {
        ERR_TIMEOUT   = 3'd0,
        ERR_TOO_LARGE = 3'd3,
        ERR_UNKNOWN   = 3'd5
    } t_err;

    typedef enum logic {
        REG_BLOCK_SIZE = 1'b0,
        REG_SESSION_SECS = 1'b1
    } t_reg;

endpackage

FILE: hdl/tftp_write_receiver_top.sv
// TFTP write receiver: input register, session update logic, result register.
// Depends on tftpwr_pkg; APB-style register port for block size and deadline.
// Path: input register, then result register. Throughput: one word per
// cycle while the result channel is not stalled; session state updates as
// a word moves from the input register into the result register.
// Reset (synchronous, active low) empties both registers, closes the session
// and restores block_size 512 and session_seconds 20.
module tftp_write_receiver_top
    import tftpwr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // event channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_action,
    input  logic                    i_sender_matches,
    input  logic [OpW-1:0]          i_pkt_opcode,
    input  logic [BlockW-1:0]       i_pkt_block,
    input  logic [LenW-1:0]         i_packet_len,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_send_kind,
    output logic [BlockW-1:0]       o_ack_block,
    output logic [2:0]              o_error_code,
    output logic                    o_to_sender,
    output logic                    o_write_data,
    output logic [LenW-1:0]         o_write_len,
    output logic [1:0]              o_status,
    // register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [AddrW-1:0]        paddr,
    input  logic [DataW-1:0]        pwdata,
    output logic [DataW-1:0]        prdata,
    output logic                    pready
);

    // configuration
    logic [LenW-1:0]   r_block_size;
    logic [SecW-1:0]   r_session_secs;

    // input register
    logic              r_in_valid;
    t_action           r_action;
    logic              r_match;
    logic [OpW-1:0]    r_opcode;
    logic [BlockW-1:0] r_blk;
    logic [LenW-1:0]   r_len;

    // session state
    logic [BlockW-1:0] r_last_block;
    logic              r_active;
    logic [SecW-1:0]   r_seconds;
    t_status           r_status;

    // result register
    logic              r_out_valid;
    t_send             r_kind;
    logic [BlockW-1:0] r_ackb;
    t_err              r_ecode;
    logic              r_tosnd;
    logic              r_wr;
    logic [LenW-1:0]   r_wlen;
    t_status           r_out_status;

    logic              advance;
    logic              cfg_wr;

    // next values
    logic [BlockW-1:0] n_last_block;
    logic              n_active;
    logic [SecW-1:0]   n_seconds;
    t_status           n_status;
    t_send             n_kind;
    logic [BlockW-1:0] n_ackb;
    t_err              n_ecode;
    logic              n_tosnd;
    logic              n_wr;
    logic [LenW-1:0]   n_wlen;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;

    always_comb begin
        if (t_reg'(paddr[2]) == REG_BLOCK_SIZE) begin
            prdata = DataW'(r_block_size);
        end else begin
            prdata = DataW'(r_session_secs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size   <= BlockSizeRst;
            r_session_secs <= SessionSecsRst;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[2]))
                REG_BLOCK_SIZE:   r_block_size   <= pwdata[LenW-1:0];
                REG_SESSION_SECS: r_session_secs <= pwdata[SecW-1:0];
                default: ;
            endcase
        end
    end

    // Session update for the word in the input register
    always_comb begin
        logic [LenW-1:0]   len_c;
        logic [LenW-1:0]   pay;
        logic [BlockW:0]   next_blk;
        logic [SecW-1:0]   secs;

        len_c    = (r_len > LenCap) ? LenCap : r_len;
        pay      = len_c - HdrLen;
        next_blk = {1'b0, r_last_block} + (BlockW+1)'(1);
        secs     = (r_seconds != SecTop) ? r_seconds + SecW'(1) : r_seconds;

        n_last_block = r_last_block;
        n_active     = r_active;
        n_seconds    = r_seconds;
        n_status     = r_status;
        n_kind       = SEND_NONE;
        n_ackb       = '0;
        n_ecode      = ERR_TIMEOUT;
        n_tosnd      = 1'b0;
        n_wr         = 1'b0;
        n_wlen       = '0;

        priority if (r_action == ACT_START) begin
            n_last_block = '0;
            n_seconds    = '0;
            n_active     = 1'b1;
            n_status     = ST_RUN;
            n_kind       = SEND_ACK;
        end else if (!r_active) begin
            // no session: nothing sent, nothing changes
        end else if (r_action == ACT_TICK) begin
            n_seconds = secs;
            if (secs > r_session_secs) begin
                n_kind   = SEND_ERROR;
                n_active = 1'b0;
                n_status = ST_FAIL;
            end
        end else if (r_action == ACT_PACKET && !r_match) begin
            n_kind  = SEND_ERROR;
            n_ecode = ERR_UNKNOWN;
            n_tosnd = 1'b1;
        end else if (r_action == ACT_EXPIRE || len_c < HdrLen) begin
            n_kind = SEND_ACK;
            n_ackb = r_last_block;
        end else if (r_opcode == OpData) begin
            if (r_blk == BlockTop) begin
                n_kind   = SEND_ERROR;
                n_ecode  = ERR_TOO_LARGE;
                n_active = 1'b0;
                n_status = ST_FAIL;
            end else if ({1'b0, r_blk} == next_blk) begin
                n_kind = SEND_ACK;
                n_ackb = r_blk;
                if (pay != '0) begin
                    n_wr   = 1'b1;
                    n_wlen = pay;
                end
                if (pay == r_block_size) begin
                    n_last_block = r_blk;
                end else begin
                    n_active = 1'b0;
                    n_status = ST_DONE;
                end
            end else begin
                // duplicate or out of order: repeat last ack
                n_kind = SEND_ACK;
                n_ackb = r_last_block;
            end
        end else if (r_opcode == OpError) begin
            n_active = 1'b0;
            n_status = ST_FAIL;
        end else begin
            n_kind   = SEND_ERROR;
            n_active = 1'b0;
            n_status = ST_FAIL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_block <= '0;
            r_active     <= 1'b0;
            r_seconds    <= '0;
            r_status     <= ST_IDLE;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_last_block <= n_last_block;
                r_active     <= n_active;
                r_seconds    <= n_seconds;
                r_status     <= n_status;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action <= t_action'(i_action);
            r_match  <= i_sender_matches;
            r_opcode <= i_pkt_opcode;
            r_blk    <= i_pkt_block;
            r_len    <= i_packet_len;
        end
        if (advance) begin
            r_kind       <= n_kind;
            r_ackb       <= n_ackb;
            r_ecode      <= n_ecode;
            r_tosnd      <= n_tosnd;
            r_wr         <= n_wr;
            r_wlen       <= n_wlen;
            r_out_status <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_send_kind  = r_kind;
    assign o_ack_block  = r_ackb;
    assign o_error_code = r_ecode;
    assign o_to_sender  = r_tosnd;
    assign o_write_data = r_wr;
    assign o_write_len  = r_wlen;
    assign o_status     = r_out_status;

    // A session is open exactly while the status reads running
    a_active_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == (r_status == ST_RUN))
        else $error("session flag and status disagree");

    // Stored payload only rides on an acknowledgement and is never empty
    a_write_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_wr) |-> (r_kind == SEND_ACK && r_wlen != '0))
        else $error("payload write without ack");

    // Errors to a stray sender are always unknown-id errors
    a_stray_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_tosnd) |-> (r_kind == SEND_ERROR && r_ecode == ERR_UNKNOWN))
        else $error("bad stray sender error");

    // A stalled result holds while the next word waits in the input register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_in_valid) |=> (r_in_valid && r_out_valid))
        else $error("word lost under stall");

    // The second count only clears on a start event
    a_secs_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_action != ACT_START) |=> (r_seconds >= $past(r_seconds)))
        else $error("second count went backward");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for tftp_write_receiver_top: session scoreboard class,
// event and reply drivers, APB register setup. Depends on tftpwr_pkg.
`timescale 1ns / 100ps

module tb_top;
    import tftpwr_pkg::*;

    localparam int ClkPeriod     = 20;
    localparam int WatchdogLimit = 4000;
    localparam int PressureHold  = 400;

    typedef struct {
        t_action           action;
        logic              sender_ok;
        logic [OpW-1:0]    opcode;
        logic [BlockW-1:0] blk;
        logic [LenW-1:0]   len;
    } t_tftp_event;

    typedef struct {
        t_send             kind;
        logic [BlockW-1:0] ack;
        logic [2:0]        err;
        logic              to_sender;
        logic              wr;
        logic [LenW-1:0]   wlen;
        t_status           status;
    } t_tftp_reply;

    class t_session_scoreboard;
        logic [LenW-1:0]   block_size;
        logic [SecW-1:0]   session_secs;
        logic [BlockW-1:0] last_block;
        bit                active;
        logic [SecW-1:0]   secs_used;
        t_status           status;
        t_tftp_reply       replies_due[$];
        int                errors;

        function new();
            reset_state();
            errors = 0;
        endfunction

        function void reset_state();
            block_size   = BlockSizeRst;
            session_secs = SessionSecsRst;
            last_block   = '0;
            active       = 1'b0;
            secs_used    = '0;
            status       = ST_IDLE;
        endfunction

        function void set_register(t_reg idx, logic [DataW-1:0] value);
            if (idx == REG_BLOCK_SIZE) begin
                block_size = value[LenW-1:0];
            end else begin
                session_secs = value[SecW-1:0];
            end
        endfunction

        function void close_session(t_status st);
            active = 1'b0;
            status = st;
        endfunction

        function t_tftp_reply next_reply(t_tftp_event ev);
            t_tftp_reply     r;
            logic [LenW-1:0] len;
            logic [LenW-1:0] pay;
            r.kind      = SEND_NONE;
            r.ack       = '0;
            r.err       = ERR_TIMEOUT;
            r.to_sender = 1'b0;
            r.wr        = 1'b0;
            r.wlen      = '0;
            // the receive buffer cuts anything longer than MaxBlock plus the header
            len = (ev.len > LenCap) ? LenCap : ev.len;
            if (ev.action == ACT_START) begin
                last_block = '0;
                secs_used  = '0;
                active     = 1'b1;
                status     = ST_RUN;
                r.kind     = SEND_ACK;
            end else if (!active) begin
                // no session: drop the event
            end else if (ev.action == ACT_TICK) begin
                if (secs_used < SecTop) secs_used = secs_used + 1'b1;
                if (secs_used > session_secs) begin
                    r.kind = SEND_ERROR;
                    close_session(ST_FAIL);
                end
            end else if (ev.action == ACT_PACKET && !ev.sender_ok) begin
                r.kind      = SEND_ERROR;
                r.err       = ERR_UNKNOWN;
                r.to_sender = 1'b1;
            end else if (ev.action == ACT_EXPIRE || len < HdrLen) begin
                r.kind = SEND_ACK;
                r.ack  = last_block;
            end else if (ev.opcode == OpData) begin
                if (ev.blk == BlockTop) begin
                    r.kind = SEND_ERROR;
                    r.err  = ERR_TOO_LARGE;
                    close_session(ST_FAIL);
                end else if ({1'b0, ev.blk} == {1'b0, last_block} + 17'd1) begin
                    pay    = len - HdrLen;
                    r.kind = SEND_ACK;
                    r.ack  = ev.blk;
                    if (pay != '0) begin
                        r.wr   = 1'b1;
                        r.wlen = pay;
                    end
                    if (pay == block_size) begin
                        last_block = ev.blk;
                    end else begin
                        close_session(ST_DONE);
                    end
                end else begin
                    r.kind = SEND_ACK;
                    r.ack  = last_block;
                end
            end else if (ev.opcode == OpError) begin
                close_session(ST_FAIL);
            end else begin
                r.kind = SEND_ERROR;
                close_session(ST_FAIL);
            end
            r.status = status;
            return r;
        endfunction

        function void note_event(t_tftp_event ev);
            replies_due.push_back(next_reply(ev));
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(t_tftp_reply got);
            t_tftp_reply want;
            if (replies_due.size() == 0) begin
                $display("%0t: reply with nothing pending, send_kind %0d", $time, got.kind);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            check_field("send_kind", want.kind, got.kind);
            check_field("ack_block", want.ack, got.ack);
            check_field("error_code", want.err, got.err);
            check_field("to_sender", want.to_sender, got.to_sender);
            check_field("write_data", want.wr, got.wr);
            check_field("write_len", want.wlen, got.wlen);
            check_field("status", want.status, got.status);
        endfunction
    endclass

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        in_action = '0;
    logic              in_sender_ok = 1'b0;
    logic [OpW-1:0]    in_opcode = '0;
    logic [BlockW-1:0] in_blk = '0;
    logic [LenW-1:0]   in_len = '0;
    logic              o_out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        o_send_kind;
    logic [BlockW-1:0] o_ack_block;
    logic [2:0]        o_error_code;
    logic              o_to_sender;
    logic              o_write_data;
    logic [LenW-1:0]   o_write_len;
    logic [1:0]        o_status;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [AddrW-1:0]  paddr = '0;
    logic [DataW-1:0]  pwdata = '0;
    logic [DataW-1:0]  prdata;
    logic              pready;

    t_session_scoreboard sb = new();
    t_tftp_reply       seen_reply;
    int                items_sent = 0;
    int                idle_cycles = 0;
    int                send_burst = 0;
    int                stall_burst = 0;
    bit                pressure_armed = 1'b0;
    bit                pressure_done = 1'b0;

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    tftp_write_receiver_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (in_action),
        .i_sender_matches (in_sender_ok),
        .i_pkt_opcode     (in_opcode),
        .i_pkt_block      (in_blk),
        .i_packet_len     (in_len),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_send_kind      (o_send_kind),
        .o_ack_block      (o_ack_block),
        .o_error_code     (o_error_code),
        .o_to_sender      (o_to_sender),
        .o_write_data     (o_write_data),
        .o_write_len      (o_write_len),
        .o_status         (o_status),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // mostly short gaps, a few long ones, and bursts with none at all
    function automatic int pick_gap(inout int burst_left);
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 60);
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_tftp_event mk(t_action a, logic m, logic [OpW-1:0] op,
                                       logic [BlockW-1:0] blk, logic [LenW-1:0] len);
        t_tftp_event ev;
        ev.action    = a;
        ev.sender_ok = m;
        ev.opcode    = op;
        ev.blk       = blk;
        ev.len       = len;
        return ev;
    endfunction

    function automatic t_tftp_event rand_event();
        return mk(t_action'($urandom_range(0, 3)), 1'($urandom), OpW'($urandom),
                  BlockW'($urandom), LenW'($urandom));
    endfunction

    // disturbance inside a running session; most leave it open
    function automatic t_tftp_event session_noise(logic [BlockW-1:0] last,
                                                  logic [LenW-1:0] full_len);
        t_tftp_event ev;
        ev = rand_event();
        case ($urandom_range(0, 5))
            0: ev.action = ACT_TICK;
            1: ev.action = ACT_EXPIRE;
            2: begin
                ev.action    = ACT_PACKET;
                ev.sender_ok = 1'b0;
            end
            3: begin
                ev = mk(ACT_PACKET, 1'b1, OpData, BlockW'($urandom), LenW'($urandom_range(0, 3)));
            end
            4: ev = mk(ACT_PACKET, 1'b1, OpData, last, full_len);
            default: begin
                ev = mk(ACT_PACKET, 1'b1, OpData, BlockW'($urandom), LenW'($urandom));
            end
        endcase
        return ev;
    endfunction

    task automatic send_event(t_tftp_event ev);
        int gap;
        gap = pick_gap(send_burst);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        in_action    <= ev.action;
        in_sender_ok <= ev.sender_ok;
        in_opcode    <= ev.opcode;
        in_blk       <= ev.blk;
        in_len       <= ev.len;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_event(ev);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [DataW-1:0] value);
        logic [DataW-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_register(idx, value);
        // read back: keep psel, restart the setup phase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        want = (idx == REG_BLOCK_SIZE) ? DataW'(sb.block_size) : DataW'(sb.session_secs);
        sb.check_field("prdata", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [DataW-1:0] bs, logic [DataW-1:0] secs);
        drain();
        write_reg(REG_BLOCK_SIZE, bs);
        write_reg(REG_SESSION_SECS, secs);
    endtask

    task automatic random_session();
        int                nblk;
        int                nticks;
        logic [LenW-1:0]   full_len;
        full_len = LenW'(sb.block_size + 4);
        send_event(mk(ACT_START, 1'($urandom), OpW'($urandom), BlockW'($urandom),
                      LenW'($urandom)));
        nblk = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
        for (int i = 1; i <= nblk; i++) begin
            if ($urandom_range(0, 3) == 0) send_event(session_noise(BlockW'(i - 1), full_len));
            send_event(mk(ACT_PACKET, 1'b1, OpData, BlockW'(i), full_len));
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                send_event(mk(ACT_PACKET, 1'b1, OpData, BlockW'(nblk + 1),
                              LenW'(HdrLen + $urandom_range(0, MaxBlock))));
            end
            5: send_event(mk(ACT_PACKET, 1'b1, OpData, BlockTop, full_len));
            6: send_event(mk(ACT_PACKET, 1'b1, OpError, BlockW'($urandom), LenW'($urandom)));
            7: send_event(mk(ACT_PACKET, 1'b1, OpW'($urandom), BlockW'($urandom),
                             LenW'($urandom_range(4, 600))));
            8: begin
                nticks = (sb.session_secs < 30) ? sb.session_secs + 1 : 30;
                repeat (nticks) begin
                    send_event(mk(ACT_TICK, 1'($urandom), OpW'($urandom), BlockW'($urandom),
                                  LenW'($urandom)));
                end
            end
            default: ;
        endcase
    endtask

    // reply monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && out_stall === 1'b0) begin
            seen_reply.kind      = t_send'(o_send_kind);
            seen_reply.ack       = o_ack_block;
            seen_reply.err       = o_error_code;
            seen_reply.to_sender = o_to_sender;
            seen_reply.wr        = o_write_data;
            seen_reply.wlen      = o_write_len;
            seen_reply.status    = t_status'(o_status);
            sb.check_reply(seen_reply);
        end
    end

    // watchdog: count cycles in which no word and no register access moves
    always @(posedge i_clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall) || psel
                || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold once random traffic runs
    initial begin
        int run;
        int hold;
        forever begin
            if (pressure_armed && !pressure_done) begin
                out_stall <= 1'b1;
                repeat (PressureHold) @(posedge i_clk);
                pressure_done = 1'b1;
            end else begin
                run = $urandom_range(1, 30);
                out_stall <= 1'b0;
                repeat (run) @(posedge i_clk);
                hold = pick_gap(stall_burst);
                if (hold > 0) begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int bs_list[6]   = '{512, 4096, 1000, 8191, 0, 512};
        int secs_list[6] = '{20, 1800, 1, 2047, 3, 5};
        int target;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(512, 1);
        // events with no session open, then a session with data, repeats and short packets
        send_event(mk(ACT_PACKET, 1'b1, OpData, 16'd1, 13'd516));
        send_event(mk(ACT_TICK, 1'b1, OpData, 16'd1, 13'd516));
        send_event(mk(ACT_EXPIRE, 1'b0, '0, '0, '0));
        send_event(mk(ACT_START, 1'b0, '0, '0, '0));
        send_event(mk(ACT_PACKET, 1'b1, OpData, 16'd1, 13'd516));
        send_event(mk(ACT_PACKET, 1'b1, OpData, 16'd1, 13'd516));
        send_event(mk(ACT_PACKET, 1'b0, '1, '1, '1));
        send_event(mk(ACT_PACKET, 1'b1, OpData, 16'd2, 13'd3));
        send_event(mk(ACT_PACKET, 1'b1, OpData, 16'd2, 13'd0));
        send_event(mk(ACT_EXPIRE, 1'b1, OpData, 16'd2, 13'd516));
        // deadline of one second: second tick fails the session
        send_event(mk(ACT_TICK, 1'b1, OpData, 16'd2, 13'd516));
        send_event(mk(ACT_TICK, 1'b1, OpData, 16'd2, 13'd516));
        // restart while running, then an empty block
        send_event(mk(ACT_START, 1'b1, '1, '1, '1));
        send_event(mk(ACT_PACKET, 1'b1, OpData, 16'd1, 13'd516));
        send_event(mk(ACT_START, 1'b1, OpData, 16'd1, 13'd516));
        send_event(mk(ACT_PACKET, 1'b1, OpData, 16'd1, 13'd4));
        send_event(mk(ACT_START, 1'b1, OpData, '0, '0));
        send_event(mk(ACT_PACKET, 1'b1, OpData, BlockTop, 13'd516));
        // oversized packet gets cut to a full buffer
        send_event(mk(ACT_START, 1'b1, OpData, '0, '0));
        send_event(mk(ACT_PACKET, 1'b1, OpData, 16'd1, '1));
        send_event(mk(ACT_START, 1'b1, OpData, '0, '0));
        send_event(mk(ACT_PACKET, 1'b1, OpError, 16'd1, 13'd516));
        send_event(mk(ACT_START, 1'b1, OpData, '0, '0));
        send_event(mk(ACT_PACKET, 1'b1, 16'hFFFF, 16'd1, 13'd516));
        send_event(mk(ACT_START, 1'b1, OpData, '0, '0));
        send_event(mk(ACT_PACKET, 1'b1, OpData, 16'd0, 13'd516));

        for (int p = 0; p < 6; p++) begin
            configure(bs_list[p], secs_list[p]);
            pressure_armed = 1'b1;
            target = items_sent + 285;
            while (items_sent < target) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_event(rand_event());
                end else begin
                    random_session();
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/tftpwr_pkg.sv
hdl/tftp_write_receiver_top.sv
tb/tb_top.sv
